// ----- design/tlqs_pkg.sv -----
// ----------------------------------------------------------------------------
// tlqs_pkg - shared types and constants for the thick line quad setup unit
// Coordinate formats and saturation helper.
// ----------------------------------------------------------------------------
package tlqs_pkg;

    localparam int COORD_W = 24;
    localparam int WIDTH_W = 23;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [WIDTH_W-1:0]        width_t;

    localparam coord_t COORD_MAX = 24'sh7FFFFF;
    localparam coord_t COORD_MIN = 24'sh800000;

    // clamp a 25-bit signed sum to the coordinate range
    function automatic coord_t sat_coord(input logic signed [COORD_W:0] v);
        coord_t r;
        if (v[COORD_W] != v[COORD_W-1])
        begin
            r = v[COORD_W] ? COORD_MIN : COORD_MAX;
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- design/thick_line_quad_setup_unit.sv -----
// ----------------------------------------------------------------------------
// thick_line_quad_setup_unit - thick line segment to quad expansion
// Offsets a segment by half its width along its normal, giving four quad
// corners plus a bounding circle (centre and radius). Q16.8 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   A segment word is taken on a rising edge with start high and busy low.
//   busy is held low: the pipeline takes a new word every cycle.
//   done rises once the word has passed the register stages below; the result
//   word sits on the output ports for one cycle and is taken at the
//   following edge. One result per segment, in order.
//   Throughput is one segment per cycle. The pipe has 84 register
//   stages, the first loaded at the accepting edge:
//   4 setup stages, 25-stage length square root, 1 stage, 23-stage offset
//   dividers, 5 corner/centre stages, 25-stage radius square root and the
//   output register.
//   Degenerate segments (start equals end) flow through the same pipe and
//   come out with degenerate set and every other field zero.
//   The receiver cannot stall: done is a strobe and the word must be
//   captured in its cycle. Reset clears every valid bit, so no spurious
//   done follows reset; payload registers are not reset.
// ----------------------------------------------------------------------------
module thick_line_quad_setup_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  tlqs_pkg::coord_t start_x,
    input  tlqs_pkg::coord_t start_y,
    input  tlqs_pkg::coord_t end_x,
    input  tlqs_pkg::coord_t end_y,
    input  tlqs_pkg::width_t line_width,
    output logic            done,
    output tlqs_pkg::coord_t corner0_x,
    output tlqs_pkg::coord_t corner0_y,
    output tlqs_pkg::coord_t corner1_x,
    output tlqs_pkg::coord_t corner1_y,
    output tlqs_pkg::coord_t corner2_x,
    output tlqs_pkg::coord_t corner2_y,
    output tlqs_pkg::coord_t corner3_x,
    output tlqs_pkg::coord_t corner3_y,
    output tlqs_pkg::coord_t center_x,
    output tlqs_pkg::coord_t center_y,
    output tlqs_pkg::width_t radius,
    output logic            degenerate
);

    import tlqs_pkg::*;

    localparam int SQ_W  = 50;   // squared length width
    localparam int RT_W  = 25;   // root width
    localparam int PM_W  = 48;   // |d| * width product
    localparam int DEN_W = 26;   // 2 * length
    localparam int QUO_W = 23;   // offset magnitude
    localparam int SB1_W = 3 + 2 * PM_W + 4 * COORD_W;
    localparam int SBY_W = 2 + 4 * COORD_W;
    localparam int SB2_W = 1 + 10 * COORD_W;

    assign busy = 1'b0;

    // ---- stage A: input capture
    logic   a_vld_reg;
    coord_t a_sx_reg, a_sy_reg, a_ex_reg, a_ey_reg;
    width_t a_w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        a_sx_reg <= start_x;
        a_sy_reg <= start_y;
        a_ex_reg <= end_x;
        a_ey_reg <= end_y;
        a_w_reg  <= line_width;
    end

    // ---- stage B: direction vector
    logic                     b_vld_reg;
    logic signed [COORD_W:0]  b_dx_reg, b_dy_reg;
    logic signed [COORD_W:0]  b_dx_next, b_dy_next;
    coord_t                   b_sx_reg, b_sy_reg, b_ex_reg, b_ey_reg;
    width_t                   b_w_reg;

    assign b_dx_next = $signed({a_ex_reg[COORD_W-1], a_ex_reg})
                     - $signed({a_sx_reg[COORD_W-1], a_sx_reg});
    assign b_dy_next = $signed({a_ey_reg[COORD_W-1], a_ey_reg})
                     - $signed({a_sy_reg[COORD_W-1], a_sy_reg});

    // ---- stage C: squares and width products
    logic               c_vld_reg;
    logic [RT_W-1:0]    c_adx, c_ady;
    logic [SQ_W-1:0]    c_sqx_reg, c_sqy_reg;
    logic [PM_W-1:0]    c_pmx_reg, c_pmy_reg;
    logic               c_nxneg_reg, c_nyneg_reg, c_deg_reg;
    coord_t             c_sx_reg, c_sy_reg, c_ex_reg, c_ey_reg;

    assign c_adx = b_dx_reg[COORD_W] ? RT_W'(-b_dx_reg) : RT_W'(b_dx_reg);
    assign c_ady = b_dy_reg[COORD_W] ? RT_W'(-b_dy_reg) : RT_W'(b_dy_reg);

    // ---- stage D: squared length
    logic               d_vld_reg;
    logic [SQ_W-1:0]    d_sum_reg;
    logic [SB1_W-1:0]   d_sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_dx_reg    <= b_dx_next;
        b_dy_reg    <= b_dy_next;
        b_sx_reg    <= a_sx_reg;
        b_sy_reg    <= a_sy_reg;
        b_ex_reg    <= a_ex_reg;
        b_ey_reg    <= a_ey_reg;
        b_w_reg     <= a_w_reg;

        c_sqx_reg   <= SQ_W'(c_adx) * SQ_W'(c_adx);
        c_sqy_reg   <= SQ_W'(c_ady) * SQ_W'(c_ady);
        c_pmx_reg   <= PM_W'(c_ady) * PM_W'(b_w_reg);
        c_pmy_reg   <= PM_W'(c_adx) * PM_W'(b_w_reg);
        // offset x follows -dy, offset y follows dx
        c_nxneg_reg <= !b_dy_reg[COORD_W] && (b_dy_reg != '0);
        c_nyneg_reg <= b_dx_reg[COORD_W];
        c_deg_reg   <= (b_dx_reg == '0) && (b_dy_reg == '0);
        c_sx_reg    <= b_sx_reg;
        c_sy_reg    <= b_sy_reg;
        c_ex_reg    <= b_ex_reg;
        c_ey_reg    <= b_ey_reg;

        d_sum_reg   <= c_sqx_reg + c_sqy_reg;
        d_sb_reg    <= {c_deg_reg, c_nxneg_reg, c_nyneg_reg, c_pmx_reg, c_pmy_reg,
                        c_sx_reg, c_sy_reg, c_ex_reg, c_ey_reg};
    end

    // ---- segment length
    logic               l_vld;
    logic [RT_W-1:0]    l_len;
    logic [SB1_W-1:0]   l_sb;

    tlqs_isqrt #(
        .IN_W  (SQ_W),
        .OUT_W (RT_W),
        .SB_W  (SB1_W)
    ) u_len_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_vld_reg),
        .radicand  (d_sum_reg),
        .in_sb     (d_sb_reg),
        .out_valid (l_vld),
        .root      (l_len),
        .out_sb    (l_sb)
    );

    // ---- stage E: rounding numerators and divisor
    logic               l_deg, l_nxneg, l_nyneg;
    logic [PM_W-1:0]    l_pmx, l_pmy;
    coord_t             l_sx, l_sy, l_ex, l_ey;
    logic [RT_W-1:0]    l_lenc;

    assign {l_deg, l_nxneg, l_nyneg, l_pmx, l_pmy, l_sx, l_sy, l_ex, l_ey} = l_sb;
    assign l_lenc = (l_len == '0) ? RT_W'(1) : l_len;

    logic               e_vld_reg;
    logic [PM_W-1:0]    e_numx_reg, e_numy_reg;
    logic [DEN_W-1:0]   e_den_reg;
    logic               e_nxneg_reg;
    logic [SBY_W-1:0]   e_sby_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
        end
        else
        begin
            e_vld_reg <= l_vld;
        end
    end

    // round(m / 2L) ties away = floor((m + L) / 2L)
    always_ff @(posedge clk)
    begin
        e_numx_reg  <= l_pmx + PM_W'(l_lenc);
        e_numy_reg  <= l_pmy + PM_W'(l_lenc);
        e_den_reg   <= {l_lenc, 1'b0};
        e_nxneg_reg <= l_nxneg;
        e_sby_reg   <= {l_deg, l_nyneg, l_sx, l_sy, l_ex, l_ey};
    end

    // ---- offset dividers
    logic               qx_vld, qy_vld;
    logic [QUO_W-1:0]   qx, qy;
    logic               qx_neg;
    logic [SBY_W-1:0]   qy_sb;

    tlqs_div #(
        .NUM_W (PM_W),
        .DEN_W (DEN_W),
        .QUO_W (QUO_W),
        .SB_W  (1)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (e_vld_reg),
        .numer     (e_numx_reg),
        .denom     (e_den_reg),
        .in_sb     (e_nxneg_reg),
        .out_valid (qx_vld),
        .quot      (qx),
        .out_sb    (qx_neg)
    );

    tlqs_div #(
        .NUM_W (PM_W),
        .DEN_W (DEN_W),
        .QUO_W (QUO_W),
        .SB_W  (SBY_W)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (e_vld_reg),
        .numer     (e_numy_reg),
        .denom     (e_den_reg),
        .in_sb     (e_sby_reg),
        .out_valid (qy_vld),
        .quot      (qy),
        .out_sb    (qy_sb)
    );

    // ---- stage F: corners
    logic               q_deg, q_nyneg;
    coord_t             q_sx, q_sy, q_ex, q_ey;
    coord_t             q_nx, q_ny;

    assign {q_deg, q_nyneg, q_sx, q_sy, q_ex, q_ey} = qy_sb;
    assign q_nx = qx_neg  ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    assign q_ny = q_nyneg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

    logic               f_vld_reg, f_deg_reg;
    coord_t             f_c_reg [8];

    // ---- stage G: corner sums
    logic               g_vld_reg, g_deg_reg;
    coord_t             g_c_reg [8];
    logic signed [COORD_W+1:0] g_sumx_reg, g_sumy_reg;

    // ---- stage H: centre and corner-0 offset
    logic               h_vld_reg, h_deg_reg;
    coord_t             h_c_reg [8];
    coord_t             h_cx_reg, h_cy_reg;
    logic signed [COORD_W:0] h_rx_reg, h_ry_reg;
    logic [COORD_W+1:0] g_magx, g_magy, g_qx_w, g_qy_w;
    coord_t             h_cx_next, h_cy_next;

    assign g_magx = g_sumx_reg[COORD_W+1] ? -g_sumx_reg : g_sumx_reg;
    assign g_magy = g_sumy_reg[COORD_W+1] ? -g_sumy_reg : g_sumy_reg;
    assign g_qx_w = (g_magx + (COORD_W+2)'(2)) >> 2;
    assign g_qy_w = (g_magy + (COORD_W+2)'(2)) >> 2;
    assign h_cx_next = g_sumx_reg[COORD_W+1] ? -$signed(g_qx_w[COORD_W-1:0])
                                             :  $signed(g_qx_w[COORD_W-1:0]);
    assign h_cy_next = g_sumy_reg[COORD_W+1] ? -$signed(g_qy_w[COORD_W-1:0])
                                             :  $signed(g_qy_w[COORD_W-1:0]);

    // ---- stage I: squares of radius vector
    logic               i_vld_reg;
    logic [RT_W-1:0]    i_arx, i_ary;
    logic [SQ_W-1:0]    i_sqx_reg, i_sqy_reg;
    logic [SB2_W-1:0]   i_sb_reg;

    assign i_arx = h_rx_reg[COORD_W] ? RT_W'(-h_rx_reg) : RT_W'(h_rx_reg);
    assign i_ary = h_ry_reg[COORD_W] ? RT_W'(-h_ry_reg) : RT_W'(h_ry_reg);

    // ---- stage J: squared radius
    logic               j_vld_reg;
    logic [SQ_W-1:0]    j_sum_reg;
    logic [SB2_W-1:0]   j_sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
            i_vld_reg <= 1'b0;
            j_vld_reg <= 1'b0;
        end
        else
        begin
            f_vld_reg <= qx_vld && qy_vld;
            g_vld_reg <= f_vld_reg;
            h_vld_reg <= g_vld_reg;
            i_vld_reg <= h_vld_reg;
            j_vld_reg <= i_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f_deg_reg  <= q_deg;
        f_c_reg[0] <= sat_coord($signed({q_sx[COORD_W-1], q_sx}) + q_nx);
        f_c_reg[1] <= sat_coord($signed({q_sy[COORD_W-1], q_sy}) + q_ny);
        f_c_reg[2] <= sat_coord($signed({q_ex[COORD_W-1], q_ex}) + q_nx);
        f_c_reg[3] <= sat_coord($signed({q_ey[COORD_W-1], q_ey}) + q_ny);
        f_c_reg[4] <= sat_coord($signed({q_ex[COORD_W-1], q_ex}) - q_nx);
        f_c_reg[5] <= sat_coord($signed({q_ey[COORD_W-1], q_ey}) - q_ny);
        f_c_reg[6] <= sat_coord($signed({q_sx[COORD_W-1], q_sx}) - q_nx);
        f_c_reg[7] <= sat_coord($signed({q_sy[COORD_W-1], q_sy}) - q_ny);

        g_deg_reg  <= f_deg_reg;
        g_c_reg    <= f_c_reg;
        g_sumx_reg <= (COORD_W+2)'(f_c_reg[0]) + (COORD_W+2)'(f_c_reg[2])
                    + (COORD_W+2)'(f_c_reg[4]) + (COORD_W+2)'(f_c_reg[6]);
        g_sumy_reg <= (COORD_W+2)'(f_c_reg[1]) + (COORD_W+2)'(f_c_reg[3])
                    + (COORD_W+2)'(f_c_reg[5]) + (COORD_W+2)'(f_c_reg[7]);

        h_deg_reg  <= g_deg_reg;
        h_c_reg    <= g_c_reg;
        h_cx_reg   <= h_cx_next;
        h_cy_reg   <= h_cy_next;
        h_rx_reg   <= $signed({g_c_reg[0][COORD_W-1], g_c_reg[0]})
                    - $signed({h_cx_next[COORD_W-1], h_cx_next});
        h_ry_reg   <= $signed({g_c_reg[1][COORD_W-1], g_c_reg[1]})
                    - $signed({h_cy_next[COORD_W-1], h_cy_next});

        i_sqx_reg  <= SQ_W'(i_arx) * SQ_W'(i_arx);
        i_sqy_reg  <= SQ_W'(i_ary) * SQ_W'(i_ary);
        i_sb_reg   <= {h_deg_reg, h_c_reg[0], h_c_reg[1], h_c_reg[2], h_c_reg[3],
                       h_c_reg[4], h_c_reg[5], h_c_reg[6], h_c_reg[7],
                       h_cx_reg, h_cy_reg};

        j_sum_reg  <= i_sqx_reg + i_sqy_reg;
        j_sb_reg   <= i_sb_reg;
    end

    // ---- radius
    logic               r_vld;
    logic [RT_W-1:0]    r_root;
    logic [SB2_W-1:0]   r_sb;

    tlqs_isqrt #(
        .IN_W  (SQ_W),
        .OUT_W (RT_W),
        .SB_W  (SB2_W)
    ) u_rad_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (j_vld_reg),
        .radicand  (j_sum_reg),
        .in_sb     (j_sb_reg),
        .out_valid (r_vld),
        .root      (r_root),
        .out_sb    (r_sb)
    );

    // ---- output register; degenerate segments zero every field
    logic               r_deg;
    coord_t             r_c [8];
    coord_t             r_cx, r_cy;
    width_t             r_rad;

    assign {r_deg, r_c[0], r_c[1], r_c[2], r_c[3], r_c[4], r_c[5], r_c[6], r_c[7],
            r_cx, r_cy} = r_sb;
    assign r_rad = (r_root[RT_W-1:WIDTH_W] != '0) ? width_t'(COORD_MAX)
                                                  : r_root[WIDTH_W-1:0];

    logic               done_reg, deg_reg;
    coord_t             c_out_reg [8];
    coord_t             cx_reg, cy_reg;
    width_t             rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= r_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        deg_reg <= r_deg;
        for (int k = 0; k < 8; k++)
        begin
            c_out_reg[k] <= r_deg ? '0 : r_c[k];
        end
        cx_reg  <= r_deg ? '0 : r_cx;
        cy_reg  <= r_deg ? '0 : r_cy;
        rad_reg <= r_deg ? '0 : r_rad;
    end

    assign done       = done_reg;
    assign degenerate = deg_reg;
    assign corner0_x  = c_out_reg[0];
    assign corner0_y  = c_out_reg[1];
    assign corner1_x  = c_out_reg[2];
    assign corner1_y  = c_out_reg[3];
    assign corner2_x  = c_out_reg[4];
    assign corner2_y  = c_out_reg[5];
    assign corner3_x  = c_out_reg[6];
    assign corner3_y  = c_out_reg[7];
    assign center_x   = cx_reg;
    assign center_y   = cy_reg;
    assign radius     = rad_reg;

endmodule

// ----- design/tlqs_isqrt.sv -----
// ----------------------------------------------------------------------------
// tlqs_isqrt - pipelined integer square root
// One root bit per stage, floor result, side data travels alongside.
// ----------------------------------------------------------------------------
module tlqs_isqrt #(
    parameter int IN_W  = 50,
    parameter int OUT_W = 25,
    parameter int SB_W  = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   radicand,
    input  logic [SB_W-1:0]   in_sb,
    output logic              out_valid,
    output logic [OUT_W-1:0]  root,
    output logic [SB_W-1:0]   out_sb
);

    localparam int TW = 2 * OUT_W + 1;

    logic              vld_reg  [OUT_W];
    logic [IN_W-1:0]   rem_reg  [OUT_W];
    logic [OUT_W-1:0]  root_reg [OUT_W];
    logic [SB_W-1:0]   sb_reg   [OUT_W];

    for (genvar s = 0; s < OUT_W; s++)
    begin : g_stage
        localparam int B = OUT_W - 1 - s;
        logic              vld_in;
        logic [IN_W-1:0]   rem_in;
        logic [OUT_W-1:0]  root_in;
        logic [SB_W-1:0]   sb_in;
        logic [TW-1:0]     remx;
        logic [TW-1:0]     trial;
        logic              ge;
        logic [IN_W-1:0]   rem_next;
        logic [OUT_W-1:0]  root_next;

        if (s == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = radicand;
            assign root_in = '0;
            assign sb_in   = in_sb;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign sb_in   = sb_reg[s-1];
        end

        // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
        assign remx      = TW'(rem_in);
        assign trial     = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
        assign ge        = remx >= trial;
        assign rem_next  = ge ? IN_W'(remx - trial) : rem_in;
        assign root_next = ge ? (root_in | (OUT_W'(1) << B)) : root_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= rem_next;
            root_reg[s] <= root_next;
            sb_reg[s]   <= sb_in;
        end
    end

    assign out_valid = vld_reg[OUT_W-1];
    assign root      = root_reg[OUT_W-1];
    assign out_sb    = sb_reg[OUT_W-1];

endmodule

// ----- design/tlqs_div.sv -----
// ----------------------------------------------------------------------------
// tlqs_div - pipelined restoring divider
// One quotient bit per stage; caller guarantees quotient fits QUO_W bits.
// ----------------------------------------------------------------------------
module tlqs_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 26,
    parameter int QUO_W = 23,
    parameter int SB_W  = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  numer,
    input  logic [DEN_W-1:0]  denom,
    input  logic [SB_W-1:0]   in_sb,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quot,
    output logic [SB_W-1:0]   out_sb
);

    localparam int RW = ((DEN_W + QUO_W) > NUM_W) ? (DEN_W + QUO_W) : NUM_W;

    logic              vld_reg [QUO_W];
    logic [NUM_W-1:0]  rem_reg [QUO_W];
    logic [DEN_W-1:0]  den_reg [QUO_W];
    logic [QUO_W-1:0]  quo_reg [QUO_W];
    logic [SB_W-1:0]   sb_reg  [QUO_W];

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        localparam int B = QUO_W - 1 - s;
        logic              vld_in;
        logic [NUM_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [QUO_W-1:0]  quo_in;
        logic [SB_W-1:0]   sb_in;
        logic [RW-1:0]     remx;
        logic [RW-1:0]     dsh;
        logic              ge;
        logic [NUM_W-1:0]  rem_next;
        logic [QUO_W-1:0]  quo_next;

        if (s == 0)
        begin : g_first
            assign vld_in = in_valid;
            assign rem_in = numer;
            assign den_in = denom;
            assign quo_in = '0;
            assign sb_in  = in_sb;
        end
        else
        begin : g_rest
            assign vld_in = vld_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign sb_in  = sb_reg[s-1];
        end

        assign remx     = RW'(rem_in);
        assign dsh      = RW'(den_in) << B;
        assign ge       = remx >= dsh;
        assign rem_next = ge ? NUM_W'(remx - dsh) : rem_in;
        assign quo_next = ge ? (quo_in | (QUO_W'(1) << B)) : quo_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next;
            den_reg[s] <= den_in;
            quo_reg[s] <= quo_next;
            sb_reg[s]  <= sb_in;
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign quot      = quo_reg[QUO_W-1];
    assign out_sb    = sb_reg[QUO_W-1];

endmodule

// ----- tb/quad_setup_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_setup_checker - result checker for the thick line quad setup unit
// Captures each accepted segment word, works out the expected quad and
// bounding circle, and compares every done word with the oldest expectation.
// ----------------------------------------------------------------------------
module quad_setup_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  tlqs_pkg::coord_t start_x,
    input  tlqs_pkg::coord_t start_y,
    input  tlqs_pkg::coord_t end_x,
    input  tlqs_pkg::coord_t end_y,
    input  tlqs_pkg::width_t line_width,
    input  logic             done,
    input  tlqs_pkg::coord_t corner0_x,
    input  tlqs_pkg::coord_t corner0_y,
    input  tlqs_pkg::coord_t corner1_x,
    input  tlqs_pkg::coord_t corner1_y,
    input  tlqs_pkg::coord_t corner2_x,
    input  tlqs_pkg::coord_t corner2_y,
    input  tlqs_pkg::coord_t corner3_x,
    input  tlqs_pkg::coord_t corner3_y,
    input  tlqs_pkg::coord_t center_x,
    input  tlqs_pkg::coord_t center_y,
    input  tlqs_pkg::width_t radius,
    input  logic             degenerate,
    output int               fail_count,
    output int               pending_count,
    output int               degen_seen,
    output int               sat_seen
);

    typedef struct {
        tlqs_pkg::coord_t c [8];
        tlqs_pkg::coord_t cen_x;
        tlqs_pkg::coord_t cen_y;
        tlqs_pkg::width_t rad;
        logic             degen;
    } quad_word_t;

    quad_word_t quad_pending [$];

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned trial;
        res = 0;
        for (int i = 31; i >= 0; i--)
        begin
            trial = res | (longint'(1) << i);
            if (trial * trial <= v)
                res = trial;
        end
        return res;
    endfunction

    // round to nearest, ties away from zero; den > 0
    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clamp24(input longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    function automatic quad_word_t expand_segment(input tlqs_pkg::coord_t sxi,
        input tlqs_pkg::coord_t syi, input tlqs_pkg::coord_t exi,
        input tlqs_pkg::coord_t eyi, input tlqs_pkg::width_t wi);
        quad_word_t q;
        longint sx, sy, ex, ey, w, dx, dy, nx, ny, cx, cy, rx, ry;
        longint len, rad;
        longint cc [8];
        sx = longint'(sxi);
        sy = longint'(syi);
        ex = longint'(exi);
        ey = longint'(eyi);
        w  = longint'({1'b0, wi});
        dx = ex - sx;
        dy = ey - sy;
        for (int i = 0; i < 8; i++)
            q.c[i] = '0;
        q.cen_x = '0;
        q.cen_y = '0;
        q.rad   = '0;
        q.degen = 1'b0;
        if (dx == 0 && dy == 0)
        begin
            q.degen = 1'b1;
            return q;
        end
        len = longint'(floor_sqrt(dx * dx + dy * dy));
        if (len == 0)
            len = 1;
        nx = round_div(-dy * w, 2 * len);
        ny = round_div(dx * w, 2 * len);
        cc[0] = clamp24(sx + nx); cc[1] = clamp24(sy + ny);
        cc[2] = clamp24(ex + nx); cc[3] = clamp24(ey + ny);
        cc[4] = clamp24(ex - nx); cc[5] = clamp24(ey - ny);
        cc[6] = clamp24(sx - nx); cc[7] = clamp24(sy - ny);
        cx = round_div(cc[0] + cc[2] + cc[4] + cc[6], 4);
        cy = round_div(cc[1] + cc[3] + cc[5] + cc[7], 4);
        rx = cc[0] - cx;
        ry = cc[1] - cy;
        rad = longint'(floor_sqrt(rx * rx + ry * ry));
        if (rad > 8388607)
            rad = 8388607;
        for (int i = 0; i < 8; i++)
            q.c[i] = cc[i][23:0];
        q.cen_x = cx[23:0];
        q.cen_y = cy[23:0];
        q.rad   = rad[22:0];
        return q;
    endfunction

    task automatic report_mismatch(input string field, input longint got,
                                   input longint want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, field,
                 got, want);
        fail_count++;
    endtask

    quad_word_t got_w;
    quad_word_t want_w;
    string      cname [8] = '{"corner0_x", "corner0_y", "corner1_x", "corner1_y",
                              "corner2_x", "corner2_y", "corner3_x", "corner3_y"};

    initial
    begin
        fail_count = 0;
        pending_count = 0;
        degen_seen = 0;
        sat_seen = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                quad_pending = {quad_pending, expand_segment(start_x, start_y,
                                                             end_x, end_y,
                                                             line_width)};
            end
            if (done)
            begin
                got_w.c = '{corner0_x, corner0_y, corner1_x, corner1_y,
                            corner2_x, corner2_y, corner3_x, corner3_y};
                if (quad_pending.size() == 0)
                begin
                    $display("%0t ns: done word with nothing outstanding", $time);
                    fail_count++;
                end
                else
                begin
                    want_w = quad_pending.pop_front();
                    for (int i = 0; i < 8; i++)
                    begin
                        if (got_w.c[i] !== want_w.c[i])
                            report_mismatch(cname[i], got_w.c[i], want_w.c[i]);
                        if (want_w.c[i] == tlqs_pkg::COORD_MAX ||
                            want_w.c[i] == tlqs_pkg::COORD_MIN)
                            sat_seen++;
                    end
                    if (center_x !== want_w.cen_x)
                        report_mismatch("center_x", center_x, want_w.cen_x);
                    if (center_y !== want_w.cen_y)
                        report_mismatch("center_y", center_y, want_w.cen_y);
                    if (radius !== want_w.rad)
                        report_mismatch("radius", radius, want_w.rad);
                    if (degenerate !== want_w.degen)
                        report_mismatch("degenerate", degenerate, want_w.degen);
                    if (want_w.degen)
                        degen_seen++;
                end
            end
            pending_count = quad_pending.size();
        end
    end

endmodule

// ----- tb/thick_line_quad_setup_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thick_line_quad_setup_unit_tb - testbench top for the quad setup unit
// Drives directed and random segment words through three idling phases;
// the checker beside the DUT predicts and compares every done word.
// ----------------------------------------------------------------------------
module thick_line_quad_setup_unit_tb;

    import tlqs_pkg::*;

    localparam int LATENCY      = 84;
    localparam int ITEMS_PHASE  = 450;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    coord_t start_x, start_y, end_x, end_y;
    width_t line_width;
    logic   done;
    coord_t corner0_x, corner0_y, corner1_x, corner1_y;
    coord_t corner2_x, corner2_y, corner3_x, corner3_y;
    coord_t center_x, center_y;
    width_t radius;
    logic   degenerate;

    int fail_count;
    int pending_count;
    int degen_seen;
    int sat_seen;
    int words_sent;
    int idle_pct;       // sender idle chance for the current phase

    thick_line_quad_setup_unit DUT (.*);

    quad_setup_checker u_checker (.*);

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop if the pipe ever hangs
    initial
    begin
        #2_000_000;
        $display("timeout with %0d words outstanding", pending_count);
        $display("** thick_line_quad_setup_unit: FAILED **");
        $finish;
    end

    // one segment word: drive on the falling edge, hold until taken
    task automatic send_segment(input coord_t sx, input coord_t sy,
                                input coord_t ex, input coord_t ey,
                                input width_t w);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start_x = sx;
        start_y = sy;
        end_x = ex;
        end_y = ey;
        line_width = w;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        words_sent++;
    endtask

    // ordinary segments, full-range noise, near-zero lengths and huge widths
    task automatic send_random;
        coord_t sx, sy, ex, ey;
        width_t w;
        int     kind;
        kind = $urandom_range(9);
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        w  = width_t'($urandom);
        if (kind < 3)
        begin
            ex = coord_t'($urandom);
            ey = coord_t'($urandom);
        end
        else if (kind < 7)
        begin
            // short-to-medium segment near the start point
            ex = sx + coord_t'($signed($urandom_range(65535)) - 32768);
            ey = sy + coord_t'($signed($urandom_range(65535)) - 32768);
            w  = width_t'($urandom_range(16384));
        end
        else if (kind < 9)
        begin
            // tiny direction vectors, including zero length
            ex = sx + coord_t'($signed($urandom_range(4)) - 2);
            ey = sy + coord_t'($signed($urandom_range(4)) - 2);
        end
        else
        begin
            // huge widths near the range edge to force clamping
            sx = $urandom_range(1) ? coord_t'(COORD_MAX - $urandom_range(4096))
                                   : coord_t'(COORD_MIN + $urandom_range(4096));
            ex = sx;
            ey = sy + coord_t'($urandom_range(1000) + 1);
            w  = width_t'('h7FFFFF - $urandom_range(65535));
        end
        send_segment(sx, sy, ex, ey, w);
    endtask

    task automatic wait_drained;
        @(negedge clk);
        start = 1'b0;
        while (pending_count != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        line_width = '0;
        words_sent = 0;
        idle_pct = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed: degenerate, zero width, axes, diagonals, extremes
        send_segment('0, '0, '0, '0, '0);
        send_segment(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 23'h7FFFFF);
        send_segment('0, '0, 24'sd256, '0, '0);
        send_segment('0, '0, 24'sd256, '0, 23'd512);
        send_segment('0, '0, '0, 24'sd256, 23'd512);
        send_segment('0, '0, -24'sd256, '0, 23'd512);
        send_segment('0, '0, '0, -24'sd256, 23'd512);
        send_segment('0, '0, 24'sd768, 24'sd1024, 23'd300);
        send_segment('0, '0, 24'sd1, '0, 23'd1);
        send_segment('0, '0, 24'sd1, 24'sd1, 23'd3);
        send_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 23'h7FFFFF);
        send_segment(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 23'h7FFFFF);
        send_segment(COORD_MIN, '0, COORD_MAX, '0, 23'h7FFFFF);
        send_segment('0, COORD_MAX, '0, COORD_MIN, 23'h7FFFFF);
        send_segment(COORD_MAX, '0, COORD_MAX, 24'sd256, 23'h7FFFFF);
        send_segment(COORD_MIN, '0, COORD_MIN, 24'sd256, 23'h7FFFFF);
        send_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, '0);
        send_segment(24'sd1000, -24'sd1000, 24'sd1000, -24'sd1000, 23'd77);
        send_segment(-24'sd5, 24'sd7, 24'sd11, -24'sd13, 23'd1000);
        send_segment(24'sd12345, 24'sd678, -24'sd9999, 24'sd4321, 23'd2);

        // let the pipe empty before the random part
        wait_drained();

        idle_pct = 10;
        repeat (ITEMS_PHASE) send_random();
        idle_pct = 78;
        repeat (ITEMS_PHASE) send_random();
        idle_pct = 0;
        repeat (ITEMS_PHASE) send_random();

        wait_drained();
        repeat (LATENCY + 16) @(posedge clk);

        $display("covered %0d segment words: %0d degenerate, %0d clamped corners",
                 words_sent, degen_seen, sat_seen);
        $display("sender idling at 10, 78 and 0 per cent, with one full drain");
        if (fail_count == 0 && pending_count == 0)
            $display("** thick_line_quad_setup_unit: PASSED **");
        else
            $display("** thick_line_quad_setup_unit: FAILED **");
        $finish;
    end

endmodule
